// ===== design/ttl_pkg.sv =====
// Package for the TTL expiry table: beat structs, command and status codes,
// operation classes and default parameter values. No dependencies.
`timescale 1ns / 1ps

package ttl_pkg;

   localparam int CAPACITY_DEF  = 256;
   localparam int BUCKETS_DEF   = 1024;
   localparam int KEY_WIDTH_DEF = 32;
   localparam int MAX_EMIT_DEF  = 64;

   localparam logic [6:0] CLEANUP_LIMIT_RESET = 7'd64;

   localparam logic [2:0] CMD_SET_REL = 3'd0;
   localparam logic [2:0] CMD_SET_ABS = 3'd1;
   localparam logic [2:0] CMD_REMOVE  = 3'd2;
   localparam logic [2:0] CMD_QUERY   = 3'd3;
   localparam logic [2:0] CMD_LIST    = 3'd4;
   localparam logic [2:0] CMD_CLEANUP = 3'd5;
   localparam logic [2:0] CMD_STATS   = 3'd6;
   localparam logic [2:0] CMD_UNKNOWN = 3'd7;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   typedef enum logic [2:0] {
      OP_SET,
      OP_REMOVE,
      OP_QUERY,
      OP_LIST,
      OP_CLEAN,
      OP_STATS,
      OP_NOP
   } op_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] key;
      logic [63:0] value;
      logic [63:0] now;
      logic [6:0]  max_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] stored_expiry;
      logic        has_expired;
      logic [63:0] remaining;
      logic [31:0] found_key;
      logic        found_valid;
      logic [6:0]  found_count;
      logic [8:0]  held_entries;
      logic [63:0] expired_total;
      logic [63:0] next_expiry;
      logic [63:0] cleanup_time;
      logic        last;
   } rsp_type;

   // A classified command as it waits between the front and the back.
   typedef struct packed {
      op_type      op;
      logic [31:0] key;
      logic [63:0] value;   // expiry time for a set, threshold for a list
      logic [63:0] now;
      logic [6:0]  limit;   // saturated scan limit
   } work_type;

endpackage

// ===== design/ttl_front.sv =====
// Front of the TTL expiry table: accepts command beats, classifies them,
// holds the cleanup limit register and a two-entry queue. Uses ttl_pkg.
`timescale 1ns / 1ps

module ttl_front #(
   parameter int MAX_EMIT = ttl_pkg::MAX_EMIT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ttl_pkg::req_type  req_data,
   input  logic              csr_wr_en,
   input  logic [6:0]        csr_wr_data,
   output logic              q_valid,
   input  logic              q_pop,
   output ttl_pkg::work_type q_item
);
   import ttl_pkg::*;

   localparam logic [6:0] EMIT_MAX = 7'(MAX_EMIT);

   logic [6:0] limit_ff, limit_in;
   work_type   queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   work_type   cls;
   logic [63:0] t_rel;
   logic [6:0]  lim_raw;

   assign busy    = (fill_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (fill_ff != 2'd0);
   assign q_item  = queue_ff[rd_ptr_ff];
   assign t_rel   = req_data.now + req_data.value;

   always_comb begin
      lim_raw   = (req_data.command == CMD_LIST) ? req_data.max_count : limit_ff;
      cls.key   = req_data.key;
      cls.now   = req_data.now;
      cls.value = req_data.value;
      cls.limit = (lim_raw > EMIT_MAX) ? EMIT_MAX : lim_raw;
      unique case (req_data.command)
         CMD_SET_REL: begin
            // A relative set that lands on zero acts as a remove.
            cls.value = t_rel;
            cls.op    = (req_data.value == 64'd0 || t_rel == 64'd0) ? OP_REMOVE : OP_SET;
         end
         CMD_SET_ABS: cls.op = (req_data.value == 64'd0) ? OP_REMOVE : OP_SET;
         CMD_REMOVE:  cls.op = OP_REMOVE;
         CMD_QUERY:   cls.op = OP_QUERY;
         CMD_LIST:    cls.op = OP_LIST;
         CMD_CLEANUP: cls.op = OP_CLEAN;
         CMD_STATS:   cls.op = OP_STATS;
         default:     cls.op = OP_NOP;
      endcase
   end

   always_comb begin
      limit_in  = csr_wr_en ? csr_wr_data : limit_ff;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= CLEANUP_LIMIT_RESET;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         limit_ff  <= limit_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== design/ttl_back.sv =====
// Back of the TTL expiry table: the entry memory, the sweep engine that does
// lookups, ordered scans and the minimum search, and the result beats. Uses ttl_pkg.
`timescale 1ns / 1ps

module ttl_back #(
   parameter int CAPACITY  = ttl_pkg::CAPACITY_DEF,
   parameter int BUCKETS   = ttl_pkg::BUCKETS_DEF,
   parameter int KEY_WIDTH = ttl_pkg::KEY_WIDTH_DEF,
   parameter int MAX_EMIT  = ttl_pkg::MAX_EMIT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  ttl_pkg::work_type q_item,
   output logic              rsp_valid,
   output ttl_pkg::rsp_type  rsp_data
);
   import ttl_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int EW = (MAX_EMIT > 1) ? $clog2(MAX_EMIT) : 1;
   localparam int NW = $clog2(MAX_EMIT + 1);
   localparam int OW = BW + 32;
   localparam logic [IW:0] SWEEP_END = (IW + 1)'(CAPACITY);
   localparam logic [CW-1:0] HELD_MAX = CW'(CAPACITY);

   typedef struct packed {
      logic [KEY_WIDTH-1:0] key;
      logic [63:0]          expiry;
      logic [31:0]          order;
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOOK, ST_APPLY, ST_SCAN, ST_STEP, ST_MIN, ST_EMIT_RD, ST_EMIT_OUT
   } state_type;

   state_type state_ff, state_in;
   work_type  work_ff, work_in;
   logic [IW:0]   cnt_ff, cnt_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [IW-1:0] rd_idx_ff;
   logic [CAPACITY-1:0] valid_ff, valid_in;

   logic          match_ff, match_in;
   logic [IW-1:0] match_idx_ff, match_idx_in;
   logic [31:0]   match_ord_ff, match_ord_in;
   logic [63:0]   match_exp_ff, match_exp_in;
   logic          free_ff, free_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;

   logic                 best_ff, best_in;
   logic [IW-1:0]        best_idx_ff, best_idx_in;
   logic [OW-1:0]        best_ord_ff, best_ord_in;
   logic [KEY_WIDTH-1:0] best_key_ff, best_key_in;
   logic                 prev_ff, prev_in;
   logic [OW-1:0]        prev_ord_ff, prev_ord_in;

   logic          min_any_ff, min_any_in;
   logic [63:0]   min_ff, min_in;
   logic [CW-1:0] held_ff, held_in;
   logic [31:0]   ins_ff, ins_in;
   logic [63:0]   expired_ff, expired_in;
   logic [63:0]   clean_ff, clean_in;
   logic [NW-1:0] nkeys_ff, nkeys_in;
   logic [EW-1:0] emit_idx_ff, emit_idx_in;

   logic [1:0]  status_ff, status_in;
   logic [63:0] stored_ff, stored_in;
   logic        expd_ff, expd_in;
   logic [63:0] remain_ff, remain_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   slot_type tbl [CAPACITY];
   slot_type tbl_rd_ff;
   logic          tbl_we;
   logic [IW-1:0] tbl_wa;
   slot_type      tbl_wd;

   logic [KEY_WIDTH-1:0] keybuf [MAX_EMIT];
   logic [KEY_WIDTH-1:0] kb_rd_ff;
   logic                 kb_we;

   logic [KEY_WIDTH-1:0] keym;
   logic          ent_valid, sweep_done, hit, is_scan, scan_hit, fin;
   logic [OW-1:0] ent_ord;

   assign keym       = KEY_WIDTH'(work_ff.key);
   assign ent_valid  = valid_ff[rd_idx_ff];
   assign ent_ord    = {BW'(tbl_rd_ff.key % BUCKETS), ins_ff - tbl_rd_ff.order};
   assign sweep_done = (cnt_ff == SWEEP_END) && !rd_vld_ff;
   assign hit        = (work_ff.op == OP_LIST) ? (tbl_rd_ff.expiry < work_ff.value)
                                               : (tbl_rd_ff.expiry <= work_ff.now);
   assign is_scan    = (work_ff.op == OP_LIST) || (work_ff.op == OP_CLEAN);
   assign scan_hit   = is_scan && (nkeys_ff != '0);
   assign fin        = !scan_hit || ((NW'(emit_idx_ff) + NW'(1)) == nkeys_ff);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      cnt_in       = cnt_ff;
      rd_vld_in    = 1'b0;
      valid_in     = valid_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      match_ord_in = match_ord_ff;
      match_exp_in = match_exp_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      best_ord_in  = best_ord_ff;
      best_key_in  = best_key_ff;
      prev_in      = prev_ff;
      prev_ord_in  = prev_ord_ff;
      min_any_in   = min_any_ff;
      min_in       = min_ff;
      held_in      = held_ff;
      ins_in       = ins_ff;
      expired_in   = expired_ff;
      clean_in     = clean_ff;
      nkeys_in     = nkeys_ff;
      emit_idx_in  = emit_idx_ff;
      status_in    = status_ff;
      stored_in    = stored_ff;
      expd_in      = expd_ff;
      remain_in    = remain_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      q_pop        = 1'b0;
      tbl_we       = 1'b0;
      tbl_wa       = free_idx_ff;
      tbl_wd       = '{key: keym, expiry: work_ff.value, order: ins_ff};
      kb_we        = 1'b0;

      // Every sweep state issues one table read a cycle until all slots are read.
      if ((state_ff == ST_LOOK || state_ff == ST_SCAN || state_ff == ST_MIN)
          && cnt_ff != SWEEP_END) begin
         rd_vld_in = 1'b1;
         cnt_in    = cnt_ff + (IW + 1)'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               work_in    = q_item;
               status_in  = STATUS_OK;
               stored_in  = '0;
               expd_in    = 1'b0;
               remain_in  = '0;
               nkeys_in   = '0;
               cnt_in     = '0;
               match_in   = 1'b0;
               free_in    = 1'b0;
               best_in    = 1'b0;
               prev_in    = 1'b0;
               min_any_in = 1'b0;
               if (q_item.op == OP_CLEAN) begin
                  clean_in = q_item.now;
               end
               case (q_item.op) inside
                  OP_SET, OP_REMOVE, OP_QUERY: state_in = ST_LOOK;
                  OP_LIST, OP_CLEAN: state_in = (q_item.limit == 7'd0) ? ST_MIN : ST_SCAN;
                  default: state_in = ST_MIN;
               endcase
            end
         end
         ST_LOOK: begin
            if (rd_vld_ff) begin
               if (ent_valid && tbl_rd_ff.key == keym) begin
                  match_in     = 1'b1;
                  match_idx_in = rd_idx_ff;
                  match_ord_in = tbl_rd_ff.order;
                  match_exp_in = tbl_rd_ff.expiry;
               end
               if (!ent_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
            end
            if (sweep_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            case (work_ff.op)
               OP_REMOVE: begin
                  if (match_ff) begin
                     valid_in[match_idx_ff] = 1'b0;
                     held_in = held_ff - CW'(1);
                  end else begin
                     status_in = STATUS_NOT_FOUND;
                  end
               end
               OP_SET: begin
                  if (match_ff) begin
                     // An update keeps the entry's place in insert order.
                     tbl_we = 1'b1;
                     tbl_wa = match_idx_ff;
                     tbl_wd = '{key: keym, expiry: work_ff.value, order: match_ord_ff};
                  end else if (held_ff >= HELD_MAX || !free_ff) begin
                     status_in = STATUS_FULL;
                  end else begin
                     tbl_we  = 1'b1;
                     valid_in[free_idx_ff] = 1'b1;
                     ins_in  = ins_ff + 32'd1;
                     held_in = held_ff + CW'(1);
                  end
               end
               OP_QUERY: begin
                  if (match_ff) begin
                     stored_in = match_exp_ff;
                     expd_in   = (match_exp_ff <= work_ff.now);
                     remain_in = (match_exp_ff > work_ff.now) ? match_exp_ff - work_ff.now
                                                              : 64'd0;
                  end
               end
               default: ;
            endcase
            cnt_in   = '0;
            state_in = ST_MIN;
         end
         ST_SCAN: begin
            // Pick the earliest hit in scan order that lies after the last one taken.
            if (rd_vld_ff && ent_valid && hit && (!prev_ff || ent_ord > prev_ord_ff)
                && (!best_ff || ent_ord < best_ord_ff)) begin
               best_in     = 1'b1;
               best_idx_in = rd_idx_ff;
               best_ord_in = ent_ord;
               best_key_in = tbl_rd_ff.key;
            end
            if (sweep_done) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cnt_in  = '0;
            best_in = 1'b0;
            if (best_ff) begin
               kb_we       = 1'b1;
               nkeys_in    = nkeys_ff + NW'(1);
               prev_in     = 1'b1;
               prev_ord_in = best_ord_ff;
               if (work_ff.op == OP_CLEAN) begin
                  valid_in[best_idx_ff] = 1'b0;
                  held_in    = held_ff - CW'(1);
                  expired_in = expired_ff + 64'd1;
               end
               state_in = ((7'(nkeys_ff) + 7'd1) == work_ff.limit) ? ST_MIN : ST_SCAN;
            end else begin
               state_in = ST_MIN;
            end
         end
         ST_MIN: begin
            if (rd_vld_ff && ent_valid && (!min_any_ff || tbl_rd_ff.expiry < min_ff)) begin
               min_any_in = 1'b1;
               min_in     = tbl_rd_ff.expiry;
            end
            if (sweep_done) begin
               emit_idx_in = '0;
               state_in    = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: begin
            rsp_valid_in         = 1'b1;
            rsp_in.status        = status_ff;
            rsp_in.stored_expiry = stored_ff;
            rsp_in.has_expired   = expd_ff;
            rsp_in.remaining     = remain_ff;
            rsp_in.found_key     = scan_hit ? 32'(kb_rd_ff) : 32'd0;
            rsp_in.found_valid   = scan_hit;
            rsp_in.found_count   = (is_scan && fin) ? 7'(nkeys_ff) : 7'd0;
            rsp_in.held_entries  = 9'(held_ff);
            rsp_in.expired_total = expired_ff;
            rsp_in.next_expiry   = min_any_ff ? min_ff : 64'd0;
            rsp_in.cleanup_time  = clean_ff;
            rsp_in.last          = fin;
            emit_idx_in          = emit_idx_ff + EW'(1);
            state_in             = fin ? ST_IDLE : ST_EMIT_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         held_ff      <= '0;
         ins_ff       <= '0;
         expired_ff   <= '0;
         clean_ff     <= '0;
         nkeys_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         valid_ff     <= valid_in;
         held_ff      <= held_in;
         ins_ff       <= ins_in;
         expired_ff   <= expired_in;
         clean_ff     <= clean_in;
         nkeys_ff     <= nkeys_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff      <= work_in;
      cnt_ff       <= cnt_in;
      rd_idx_ff    <= cnt_ff[IW-1:0];
      match_ff     <= match_in;
      match_idx_ff <= match_idx_in;
      match_ord_ff <= match_ord_in;
      match_exp_ff <= match_exp_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      best_ord_ff  <= best_ord_in;
      best_key_ff  <= best_key_in;
      prev_ff      <= prev_in;
      prev_ord_ff  <= prev_ord_in;
      min_any_ff   <= min_any_in;
      min_ff       <= min_in;
      emit_idx_ff  <= emit_idx_in;
      status_ff    <= status_in;
      stored_ff    <= stored_in;
      expd_ff      <= expd_in;
      remain_ff    <= remain_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl[tbl_wa] <= tbl_wd;
      end
      tbl_rd_ff <= tbl[cnt_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (kb_we) begin
         keybuf[nkeys_ff[EW-1:0]] <= best_key_ff;
      end
      kb_rd_ff <= keybuf[emit_idx_ff];
   end

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HELD_MAX)
      else $error("entry count above capacity");

   a_nkeys_bound: assert property (@(posedge clock) disable iff (reset)
      nkeys_ff <= NW'(MAX_EMIT))
      else $error("scan emitted more keys than allowed");

   a_beat_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result beats back to back");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE && q_valid))
      else $error("queue popped while a command is in progress");

endmodule

// ===== design/ttl_expiry_table_core.sv =====
// Top level of the TTL expiry table: front (classify and queue) and back
// (entry memory and sweep engine). Uses ttl_pkg, ttl_front and ttl_back.
`timescale 1ns / 1ps

// Usage:
// A command beat is taken on req_data at a rising edge where start is high
// and busy is low. The front classifies it and holds up to two commands in a
// queue, so busy rises only when both entries wait for the back.
// The back answers each command with one or more result beats on rsp_data,
// each marked by rsp_valid for exactly one cycle; rsp_data.last flags the
// final beat. The receiver cannot stall, so beats leave as soon as they form.
// Every command sweeps the entry memory through its single read port, one
// slot a cycle. Set, remove and query take a lookup sweep, an apply state
// and a minimum sweep. Stats take one sweep. A list or cleanup that emits
// k keys takes k + 1 ordered sweeps (k when it stops at its limit, none
// when the limit is zero) plus the minimum sweep; its result beats then
// follow one another, never back to back.
// The cleanup limit must be written through csr_wr_en and csr_wr_data by
// the user only while idle; the block itself does not enforce this.
// Reset clears all valid bits, counters and the queue at once; no sweep is
// needed and commands are taken in the cycle after reset falls.
module ttl_expiry_table_core #(
   parameter int CAPACITY  = ttl_pkg::CAPACITY_DEF,
   parameter int BUCKETS   = ttl_pkg::BUCKETS_DEF,
   parameter int KEY_WIDTH = ttl_pkg::KEY_WIDTH_DEF,
   parameter int MAX_EMIT  = ttl_pkg::MAX_EMIT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ttl_pkg::req_type req_data,
   input  logic             csr_wr_en,
   input  logic [6:0]       csr_wr_data,
   output logic             rsp_valid,
   output ttl_pkg::rsp_type rsp_data
);
   import ttl_pkg::*;

   logic     q_valid;
   logic     q_pop;
   work_type q_item;

   ttl_front #(
      .MAX_EMIT (MAX_EMIT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_item      (q_item)
   );

   ttl_back #(
      .CAPACITY  (CAPACITY),
      .BUCKETS   (BUCKETS),
      .KEY_WIDTH (KEY_WIDTH),
      .MAX_EMIT  (MAX_EMIT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== verif/ttl_expiry_table_checker.sv =====
// Checker for the TTL expiry table: watches command and result beats, keeps
// its own copy of the table and compares every result beat. Uses ttl_pkg.
`timescale 1ns / 1ps

module ttl_expiry_table_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  ttl_pkg::req_type req_data,
   input  logic             csr_wr_en,
   input  logic [6:0]       csr_wr_data,
   input  logic             rsp_valid,
   input  ttl_pkg::rsp_type rsp_data,
   output int               outstanding,
   output int               fail_count,
   output int               beats_checked
);
   import ttl_pkg::*;

   localparam int SLOTS = CAPACITY_DEF;

   logic [31:0] slot_key[SLOTS];
   logic [63:0] slot_expiry[SLOTS];
   bit          slot_used[SLOTS];
   logic [31:0] slot_age_stamp[SLOTS];
   logic [31:0] insert_stamp;
   int          held;
   logic [63:0] removed_total;
   logic [63:0] last_sweep_time;
   logic [6:0]  sweep_limit;

   rsp_type expected_beats[$];

   assign outstanding = expected_beats.size();

   function automatic int lookup_slot(logic [31:0] key);
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && slot_key[i] == key)
            return i;
      return -1;
   endfunction

   function automatic logic [1:0] drop_key(logic [31:0] key);
      int s;
      s = lookup_slot(key);
      if (s < 0)
         return STATUS_NOT_FOUND;
      slot_used[s] = 0;
      held--;
      return STATUS_OK;
   endfunction

   function automatic logic [1:0] store_expiry(logic [31:0] key, logic [63:0] t);
      int s;
      if (t == 0)
         return drop_key(key);
      s = lookup_slot(key);
      if (s >= 0) begin
         slot_expiry[s] = t;
         return STATUS_OK;
      end
      if (held >= SLOTS)
         return STATUS_FULL;
      for (int i = 0; i < SLOTS; i++) begin
         if (!slot_used[i]) begin
            slot_used[i] = 1;
            slot_key[i] = key;
            slot_expiry[i] = t;
            slot_age_stamp[i] = insert_stamp;
            insert_stamp++;
            held++;
            return STATUS_OK;
         end
      end
      return STATUS_FULL;
   endfunction

   // Scan order: ascending bucket, then youngest entry first within a bucket.
   function automatic bit scans_ahead(int a, int b);
      logic [31:0] age_a, age_b;
      if (slot_key[a] % BUCKETS_DEF != slot_key[b] % BUCKETS_DEF)
         return slot_key[a] % BUCKETS_DEF < slot_key[b] % BUCKETS_DEF;
      age_a = insert_stamp - slot_age_stamp[a];
      age_b = insert_stamp - slot_age_stamp[b];
      return age_a < age_b;
   endfunction

   function automatic logic [63:0] earliest_expiry();
      bit          any;
      logic [63:0] m;
      any = 0;
      m = 0;
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && (!any || slot_expiry[i] < m)) begin
            m = slot_expiry[i];
            any = 1;
         end
      return m;
   endfunction

   task automatic predict_command(req_type r);
      logic [1:0]  status;
      logic [63:0] stored, remain, t;
      logic        expired;
      bit          is_scan;
      int          walk[$];
      int          hits[$];
      logic [31:0] hit_keys[$];
      int          j, lim, beats;
      rsp_type     b;
      status = STATUS_OK;
      stored = 0;
      remain = 0;
      expired = 0;
      is_scan = 0;
      case (r.command) inside
         CMD_SET_REL: begin
            t = r.now + r.value;
            status = (r.value == 0) ? drop_key(r.key) : store_expiry(r.key, t);
         end
         CMD_SET_ABS: status = store_expiry(r.key, r.value);
         CMD_REMOVE:  status = drop_key(r.key);
         CMD_QUERY: begin
            j = lookup_slot(r.key);
            if (j >= 0) begin
               stored = slot_expiry[j];
               expired = stored <= r.now;
               remain = (stored > r.now) ? stored - r.now : 64'd0;
            end
         end
         CMD_LIST, CMD_CLEANUP: begin
            is_scan = 1;
            lim = (r.command == CMD_LIST) ? int'(r.max_count) : int'(sweep_limit);
            if (lim > MAX_EMIT_DEF)
               lim = MAX_EMIT_DEF;
            for (int i = 0; i < SLOTS; i++) begin
               if (!slot_used[i])
                  continue;
               j = walk.size();
               walk.push_back(i);
               while (j > 0 && scans_ahead(i, walk[j-1])) begin
                  walk[j] = walk[j-1];
                  j--;
               end
               walk[j] = i;
            end
            foreach (walk[i]) begin
               if (hits.size() >= lim)
                  break;
               if (r.command == CMD_LIST ? slot_expiry[walk[i]] < r.value
                                         : slot_expiry[walk[i]] <= r.now) begin
                  hits.push_back(walk[i]);
                  hit_keys.push_back(slot_key[walk[i]]);
               end
            end
            if (r.command == CMD_CLEANUP) begin
               foreach (hits[i]) begin
                  slot_used[hits[i]] = 0;
                  held--;
                  removed_total++;
               end
               last_sweep_time = r.now;
            end
         end
         default: ;
      endcase
      beats = (hits.size() > 0) ? hits.size() : 1;
      for (int k = 0; k < beats; k++) begin
         b = '0;
         b.status = status;
         b.stored_expiry = stored;
         b.has_expired = expired;
         b.remaining = remain;
         b.found_key = (hits.size() > 0) ? hit_keys[k] : 32'd0;
         b.found_valid = hits.size() > 0;
         b.found_count = (is_scan && k == beats - 1) ? 7'(hits.size()) : 7'd0;
         b.held_entries = 9'(held);
         b.expired_total = removed_total;
         b.next_expiry = earliest_expiry();
         b.cleanup_time = last_sweep_time;
         b.last = (k == beats - 1);
         expected_beats.push_back(b);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 0;
            slot_key[i] = 0;
            slot_expiry[i] = 0;
            slot_age_stamp[i] = 0;
         end
         insert_stamp = 0;
         held = 0;
         removed_total = 0;
         last_sweep_time = 0;
         sweep_limit = CLEANUP_LIMIT_RESET;
         expected_beats.delete();
         fail_count = 0;
         beats_checked = 0;
      end else begin
         if (rsp_valid) begin
            beats_checked++;
            if (expected_beats.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result beat %h", $realtime, rsp_data);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_data !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                              $realtime, want, rsp_data);
               end
            end
         end
         if (csr_wr_en)
            sweep_limit = csr_wr_data;
         if (start && !busy)
            predict_command(req_data);
      end
   end

endmodule

// ===== verif/testbench.sv =====
// Top of the TTL expiry table testbench: clock, reset, command stimulus and
// the verdict. Uses ttl_pkg, ttl_expiry_table_core and the checker module.
`timescale 1ns / 1ps

module testbench;
   import ttl_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_data = '0;
   logic    csr_wr_en = 0;
   logic [6:0] csr_wr_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      outstanding, fail_count, beats_checked;
   int      commands_sent = 0;
   int      idle_pct = 0;
   logic [63:0] wall = 64'd1000;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   ttl_expiry_table_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   ttl_expiry_table_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .outstanding(outstanding), .fail_count(fail_count), .beats_checked(beats_checked)
   );

   function automatic logic [63:0] any64();
      return {$urandom, $urandom};
   endfunction

   // Holds the beat until the edge that takes it; start stays high when the
   // next beat follows without a gap.
   task automatic send(logic [2:0] cmd, logic [31:0] key, logic [63:0] value,
                       logic [63:0] now, logic [6:0] max_count);
      while ($urandom_range(99) < idle_pct) begin
         start = 0;
         @(negedge clock);
      end
      req_data = '{command: cmd, key: key, value: value, now: now, max_count: max_count};
      start = 1;
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
      commands_sent++;
      @(negedge clock);
      start = 0;
   endtask

   task automatic write_limit(logic [6:0] v);
      wait (outstanding == 0);
      repeat (10) @(negedge clock);
      csr_wr_en = 1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 0;
   endtask

   task automatic random_command();
      logic [2:0]  cmd;
      logic [31:0] key;
      logic [63:0] value, now;
      logic [6:0]  maxc;
      int          pick;
      wall += $urandom_range(0, 20);
      now = ($urandom_range(99) < 10) ? any64() : wall;
      pick = $urandom_range(99);
      if (pick < 30)      cmd = CMD_SET_REL;
      else if (pick < 45) cmd = CMD_SET_ABS;
      else if (pick < 55) cmd = CMD_REMOVE;
      else if (pick < 73) cmd = CMD_QUERY;
      else if (pick < 82) cmd = CMD_LIST;
      else if (pick < 89) cmd = CMD_CLEANUP;
      else if (pick < 96) cmd = CMD_STATS;
      else                cmd = CMD_UNKNOWN;
      pick = $urandom_range(99);
      if (pick < 50)      key = 32'h1000 + $urandom_range(0, 299);
      else if (pick < 75) key = $urandom_range(0, 7) * 1024 + 3;
      else                key = $urandom;
      pick = $urandom_range(99);
      case (cmd)
         CMD_SET_REL: value = (pick < 85) ? 64'($urandom_range(0, 60)) : any64();
         CMD_SET_ABS: value = (pick < 8) ? 64'd0 : (pick < 85) ?
                              wall + $urandom_range(0, 60) : any64();
         CMD_LIST:    value = (pick < 85) ? wall + $urandom_range(0, 40) : any64();
         default:     value = any64();
      endcase
      pick = $urandom_range(99);
      maxc = (pick < 75) ? 7'($urandom_range(1, 4)) : 7'($urandom);
      send(cmd, key, value, now, maxc);
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset = 0;
      // Directed: empty-table cases, wrap, same-bucket order, saturation.
      send(CMD_STATS, 0, 0, 0, 0);
      send(CMD_QUERY, 32'd5, 0, 100, 0);
      send(CMD_REMOVE, 32'd5, 0, 100, 0);
      send(CMD_LIST, 0, '1, 100, 7'd64);
      send(CMD_CLEANUP, 0, 0, 100, 0);
      send(CMD_SET_REL, 32'd5, 64'd10, 100, 0);
      send(CMD_SET_REL, 32'd1029, 64'd1, 100, 0);
      send(CMD_SET_ABS, 32'hFFFF_FFFF, '1, 100, 0);
      send(CMD_SET_ABS, 32'd7, 0, 100, 0);
      send(CMD_SET_REL, 32'd9, 0, 100, 0);
      send(CMD_SET_REL, 32'd12, -64'd50, 64'd50, 0);
      send(CMD_SET_REL, 32'd13, '1, 64'd100, 0);
      send(CMD_QUERY, 32'd5, 0, 105, 0);
      send(CMD_QUERY, 32'd5, 0, 110, 0);
      send(CMD_QUERY, 32'd13, 0, 200, 0);
      send(CMD_SET_ABS, 32'd5, 64'd50, 100, 0);
      send(CMD_LIST, 0, '1, 100, 7'd0);
      send(CMD_LIST, 0, '1, 100, 7'd127);
      send(CMD_LIST, 0, 64'd100, 100, 7'd1);
      send(CMD_CLEANUP, 0, 0, 120, 0);
      send(CMD_REMOVE, 32'd1029, 0, 120, 0);
      send(CMD_UNKNOWN, $urandom, any64(), any64(), 7'($urandom));
      send(CMD_STATS, 0, 0, 130, 0);
      // Fill the table past capacity, then sweep with a saturating limit.
      write_limit(7'd127);
      for (int i = 0; i < 258; i++)
         send(CMD_SET_ABS, 32'h1000 + i, 64'd1000 + i % 40, 64'd1000, 0);
      send(CMD_CLEANUP, 0, 0, 64'd1020, 0);
      write_limit(7'd1);
      idle_pct = 13;
      for (int i = 0; i < 10; i++) random_command();
      write_limit(7'd0);
      idle_pct = 63;
      for (int i = 0; i < 9; i++) random_command();
      write_limit(7'd5);
      idle_pct = 0;
      for (int i = 0; i < 9; i++) random_command();
      wait (outstanding == 0);
      repeat (50) @(posedge clock);
      $display("Covered %0d commands (directed, full table, random) and %0d result beats.",
               commands_sent, beats_checked);
      if (fail_count == 0)
         $display("ttl_expiry_table_core regression: pass");
      else
         $display("ttl_expiry_table_core regression: fail");
      $finish;
   end

   initial begin
      #60ms;
      $display("Timed out with %0d results outstanding.", outstanding);
      $display("ttl_expiry_table_core regression: fail");
      $finish;
   end

endmodule
